// ===== design/topic_subscription_match_table_defines.svh =====
// Assertion helpers
`ifndef TOPIC_SUBSCRIPTION_MATCH_TABLE_DEFINES_SVH
`define TOPIC_SUBSCRIPTION_MATCH_TABLE_DEFINES_SVH
`define TSMT_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error("%m failed");
`define TSMT_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error("%m failed");
`endif

// ===== design/tsmt_pkg.sv =====
package tsmt_pkg;
  localparam int NumTopicsDef = 8;
  localparam int SlotsDef = 4;
  localparam int ResultLimit = 32;

  typedef enum logic [1:0] {
    REQ_SUB   = 2'd0,
    REQ_UNSUB = 2'd1,
    REQ_PUB   = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NOSLT = 2'd2,
    ST_SKIP  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } fsm_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] topic;
    logic [31:0] topic_mask;
    logic        match_kind;
    logic [7:0]  subscriber_id;
    logic        final_entry;
    logic [63:0] payload;
  } req_item_t;

  typedef struct packed {
    logic        deliver;
    logic [7:0]  target_id;
    logic [63:0] message_out;
    logic [1:0]  status;
    logic [3:0]  removed_count;
    logic        last;
  } res_item_t;

  // Token travelling down the chain of cells
  typedef struct packed {
    logic found;
    logic claimed;
    logic slot_taken;
    logic [3:0] removed;
  } token_t;
endpackage

// ===== design/tsmt_if.sv =====
interface tsmt_req_if import tsmt_pkg::*; ();
  logic valid;
  logic ready;
  req_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tsmt_res_if import tsmt_pkg::*; ();
  logic valid;
  logic ready;
  res_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/tsmt_cell.sv =====
module tsmt_cell import tsmt_pkg::*; #(
  parameter int Slots = SlotsDef
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             do_find,
  input  logic             do_claim,
  input  logic             do_unsub,
  input  req_item_t        req,
  input  token_t           tok_in,
  output token_t           tok_out,
  input  logic             pub_hit_en,
  output logic             pub_hit,
  output logic [Slots-1:0] act,
  output logic [Slots*8-1:0] owners
);
  localparam int SW = (Slots > 1) ? $clog2(Slots) : 1;

  logic              valid;
  logic [31:0]       etopic;
  logic [31:0]       emask;
  logic              ekind;
  logic [Slots-1:0]  sact;
  logic [7:0]        sown [Slots];
  logic              sub_match;
  logic              unsub_match;
  logic [31:0]       key;
  logic              has_free;
  logic [SW-1:0]     free_idx;
  logic              has_own;
  logic [SW-1:0]     own_idx;
  logic              take_find;
  logic              take_claim;

  assign key = req.match_kind ? (req.topic & req.topic_mask) : req.topic;
  assign sub_match = valid && (ekind == req.match_kind) &&
    (req.match_kind ? ((emask == req.topic_mask) &&
                       ((etopic & emask) == (req.topic & req.topic_mask)))
                    : (etopic == req.topic));
  assign unsub_match = valid && (etopic == key);
  assign pub_hit = pub_hit_en && valid &&
    (ekind ? ((emask != '0) && ((etopic & emask) == (req.topic & emask)))
           : (etopic == req.topic));

  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    has_own = 1'b0;
    own_idx = '0;
    for (int s = Slots - 1; s >= 0; s--) begin
      if (!sact[s]) begin
        has_free = 1'b1;
        free_idx = SW'(s);
      end
      if (sact[s] && sown[s] == req.subscriber_id) begin
        has_own = 1'b1;
        own_idx = SW'(s);
      end
    end
  end

  assign take_find = do_find && !tok_in.found && sub_match;
  assign take_claim = do_claim && !tok_in.found && !valid;

  always_comb begin
    tok_out = tok_in;
    if (take_find || take_claim) begin
      tok_out.found = 1'b1;
      tok_out.claimed = take_claim;
      tok_out.slot_taken = has_free || take_claim;
    end
    if (do_unsub && unsub_match && has_own && tok_in.removed != 4'd15) begin
      tok_out.removed = tok_in.removed + 4'd1;
    end else if (do_unsub && unsub_match && has_own) begin
      tok_out.removed = tok_in.removed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      sact <= '0;
    end else begin
      if (take_claim) begin
        valid <= 1'b1;
        etopic <= key;
        emask <= req.topic_mask;
        ekind <= req.match_kind;
        sact <= Slots'(1);
        sown[0] <= req.subscriber_id;
      end else if (take_find && has_free) begin
        sact[free_idx] <= 1'b1;
        sown[free_idx] <= req.subscriber_id;
      end else if (do_unsub && unsub_match && has_own) begin
        sact[own_idx] <= 1'b0;
      end
    end
  end

  always_comb begin
    act = sact;
    for (int s = 0; s < Slots; s++) owners[s*8 +: 8] = sown[s];
  end
endmodule

// ===== design/topic_subscription_match_table.sv =====
// Channel | Dir | Payload
// req     | in  | req_type topic topic_mask match_kind subscriber_id final_entry payload
// res     | out | deliver target_id message_out status removed_count last
// Subscribe: find, claim, then result; when skipped after an abort, the result alone.
// Unsubscribe and unused type: scan, then result.
// Publish: hits are latched in the scan state, then the emit scanner visits one slot per cycle
// in table order; each delivery holds the scanner until it leaves; stop after the last.
// Reset clears entry valid bits, slot activity and the abort flag at once.
// A held result stalls the scanner; no new request is taken until the last result leaves.
module topic_subscription_match_table import tsmt_pkg::*; #(
  parameter int NumTopics = NumTopicsDef,
  parameter int Slots = SlotsDef
) (
  input logic clk,
  input logic rst,
  tsmt_req_if.sink req,
  tsmt_res_if.source res
);
  `include "topic_subscription_match_table_defines.svh"
  localparam int EW = (NumTopics > 1) ? $clog2(NumTopics) : 1;
  localparam int SW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int NP = NumTopics * Slots;
  localparam int PW = $clog2(NP + 1);

  fsm_t state, state_next;
  req_item_t cur;
  logic [1:0] phase;
  logic aborted;
  token_t tok [NumTopics+1];
  logic [NumTopics-1:0] hit_now, hits;
  logic [Slots-1:0] act [NumTopics];
  logic [Slots*8-1:0] own [NumTopics];
  logic [EW-1:0] ei;
  logic [SW-1:0] si;
  logic [5:0] sent;
  logic out_busy;
  res_item_t out_item;
  logic is_sub, is_unsub;
  logic do_find, do_claim, do_unsub, latch_hits;
  logic cur_act, at_end, emit_fire;
  logic found_r, slot_r;
  logic [NP-1:0] pend;
  logic [PW-1:0] pos;
  logic more;
  logic last_dlv;
  status_t sub_status;
  logic sub_full;

  assign is_sub = cur.req_type == REQ_SUB;
  assign is_unsub = cur.req_type == REQ_UNSUB;
  assign do_find = state == S_SCAN && phase == 2'd0 && is_sub && !aborted;
  assign do_claim = state == S_SCAN && phase == 2'd1 && is_sub && !aborted;
  assign do_unsub = state == S_SCAN && phase == 2'd0 && is_unsub;
  assign latch_hits = state == S_SCAN && cur.req_type == REQ_PUB;
  assign tok[0] = '0;

  for (genvar g = 0; g < NumTopics; g++) begin : g_cell
    tsmt_cell #(.Slots(Slots)) u_cell (
      .clk, .rst, .do_find,
      .do_claim(do_claim && !found_r), .do_unsub, .req(cur),
      .tok_in(tok[g]), .tok_out(tok[g+1]), .pub_hit_en(latch_hits),
      .pub_hit(hit_now[g]), .act(act[g]), .owners(own[g])
    );
  end

  assign req.ready = state == S_IDLE && !out_busy;
  assign res.valid = out_busy;
  assign res.data = out_item;

  always_comb begin
    for (int e = 0; e < NumTopics; e++)
      for (int s = 0; s < Slots; s++) pend[e*Slots+s] = hits[e] && act[e][s];
  end

  always_comb begin
    sub_full = 1'b0;
    if (aborted) sub_status = ST_SKIP;
    else if (found_r) sub_status = slot_r ? ST_OK : ST_NOSLT;
    else if (tok[NumTopics].found) sub_status = ST_OK;
    else begin
      sub_status = ST_FULL;
      sub_full = 1'b1;
    end
  end

  assign pos = PW'(ei) * PW'(Slots) + PW'(si);
  assign more = |((pend >> pos) >> 1);
  assign cur_act = hits[ei] && act[ei][si];
  assign at_end = (32'(ei) == NumTopics - 1) && (32'(si) == Slots - 1);
  assign last_dlv = !more || sent == 6'd31;
  assign emit_fire = state == S_EMIT && !out_busy;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req.valid && req.ready) state_next = S_SCAN;
      S_SCAN: begin
        if (cur.req_type == REQ_PUB) state_next = S_EMIT;
        else if (!(is_sub && !aborted && phase == 2'd0)) state_next = S_IDLE;
      end
      S_EMIT: if (emit_fire && (at_end || (cur_act && last_dlv))) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_busy <= 1'b0;
      aborted <= 1'b0;
      phase <= '0;
    end else begin
      state <= state_next;
      if (res.valid && res.ready) out_busy <= 1'b0;
      if (state == S_IDLE && req.valid && req.ready) begin
        cur <= req.data;
        phase <= '0;
        ei <= '0;
        si <= '0;
        sent <= '0;
      end
      if (state == S_SCAN) begin
        phase <= phase + 2'd1;
        if (phase == 2'd0) begin
          found_r <= tok[NumTopics].found;
          slot_r <= tok[NumTopics].slot_taken;
        end
        if (latch_hits) hits <= hit_now;
        if (is_unsub) begin
          out_busy <= 1'b1;
          out_item <= '{1'b0, 8'd0, 64'd0, ST_OK, tok[NumTopics].removed, 1'b1};
        end else if (is_sub && (aborted || phase == 2'd1)) begin
          out_busy <= 1'b1;
          out_item <= '{1'b0, 8'd0, 64'd0, sub_status, 4'd0, 1'b1};
          aborted <= !cur.final_entry && (aborted || sub_full);
        end else if (cur.req_type == REQ_NONE) begin
          out_busy <= 1'b1;
          out_item <= '{1'b0, 8'd0, 64'd0, ST_OK, 4'd0, 1'b1};
        end
      end
      if (emit_fire) begin
        if (32'(si) == Slots - 1) begin
          si <= '0;
          ei <= ei + EW'(1);
        end else si <= si + SW'(1);
        if (cur_act) begin
          sent <= sent + 6'd1;
          out_busy <= 1'b1;
          out_item <= '{1'b1, own[ei][32'(si)*8 +: 8], cur.payload, ST_OK, 4'd0, last_dlv};
        end else if (at_end) begin
          out_busy <= 1'b1;
          out_item <= '{1'b0, 8'd0, 64'd0, ST_OK, 4'd0, 1'b1};
        end
      end
    end
  end

  `TSMT_ASSERT(a_ready_idle, !(req.ready && state != S_IDLE))
  `TSMT_ASSERT_IMPL(a_emit_cap, state == S_EMIT, sent <= 6'd32)
endmodule
